### src/serial_frame_deframer_sum8_core_defines.svh
// Assertion helpers for the frame deframer.
`ifndef SERIAL_FRAME_DEFRAMER_SUM8_CORE_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_SUM8_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 6;
  localparam int IDX_W           = 5;
  localparam int CFG_ADDR_W      = 3;
  localparam int MAX_PAYLOAD_DEF = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_FIRST     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER_SECOND    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PROTOCOL_VERSION = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH_LIMIT     = 3'd3;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST     = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST    = 8'hAA;
  localparam logic [BYTE_W-1:0] PROTOCOL_VERSION_RST = 8'h00;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST     = 6'd32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD1,
    PH_HEAD2,
    PH_VER,
    PH_CMD,
    PH_LENHI,
    PH_DATA,
    PH_CHECK
  } phase_t;

endpackage
`default_nettype wire

### src/serial_frame_deframer_sum8_core.sv
// Channel | Direction | Handshake          | Fields
// in      | input     | in_valid/in_stall  | in_rx_byte
// out     | output    | out_valid/out_stall| out_frame_status through out_last, 7 fields
// cfg     | input     | cfg_we             | cfg_addr, cfg_wdata
//
// One received byte is taken per cycle while a frame is being parsed and in_stall is
// low. A good checksum with payload drains the store at one result per cycle while
// out_stall is low, set by its single read port, via drain_r to the output registers;
// input stalls until the drain ends. Other checksum outcomes give one result, shown in
// the cycle after the checksum transfer. The checksum byte stalls while a previous
// result still waits on out_stall. Reset (rst_n low, synchronous) restores the config
// and control registers and returns to idle; the payload store needs no clearing.
`default_nettype none
`include "serial_frame_deframer_sum8_core_defines.svh"
module serial_frame_deframer_sum8_core #(
  parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sfd_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_frame_status,
  output logic [sfd_pkg::BYTE_W-1:0]           out_command,
  output logic [sfd_pkg::LEN_W-1:0]            out_payload_length,
  output logic                                 out_data_valid,
  output logic [sfd_pkg::BYTE_W-1:0]           out_payload_byte,
  output logic [sfd_pkg::IDX_W-1:0]            out_byte_index,
  output logic                                 out_last,
  input  wire logic                            cfg_we,
  input  wire logic [sfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [sfd_pkg::BYTE_W-1:0]      cfg_wdata
);
  import sfd_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_PAYLOAD);

  // configuration
  logic [BYTE_W-1:0] hdr1_r, hdr2_r, ver_r;
  logic [LEN_W-1:0]  limit_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;

  // drain and output stage
  logic              drain_r, drain_nxt;
  logic [LEN_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_dv_r, out_dv_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_last_r, out_last_nxt;
  logic [BYTE_W-1:0] out_cmd_r, out_cmd_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  logic              in_fire, slot_free, rd_issue, wr_en, sum_ok, too_long;
  logic [LEN_W:0]    lim;
  logic [LEN_W:0]    cnt_inc;
  logic [LEN_W:0]    rd_next;

  assign in_stall  = drain_r || ((phase_r == PH_CHECK) && out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign rd_issue  = drain_r && slot_free;
  assign sum_ok    = (in_rx_byte == sum_r);
  assign lim       = ({1'b0, limit_r} > MAX_LEN) ? MAX_LEN : {1'b0, limit_r};
  assign too_long  = (len_hi_r != '0) || (in_rx_byte > {1'b0, lim});
  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign rd_next   = {1'b0, rd_ptr_r} + 1'b1;

  always_comb begin : next_phase
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE:  if (in_rx_byte == hdr1_r) phase_nxt = PH_HEAD1;
        PH_HEAD1: phase_nxt = (in_rx_byte == hdr2_r) ? PH_HEAD2 : PH_IDLE;
        PH_HEAD2: phase_nxt = (in_rx_byte == ver_r) ? PH_VER : PH_IDLE;
        PH_VER:   phase_nxt = PH_CMD;
        PH_CMD:   phase_nxt = PH_LENHI;
        PH_LENHI: begin
          if (too_long) phase_nxt = PH_IDLE;
          else if (in_rx_byte != '0) phase_nxt = PH_DATA;
          else phase_nxt = PH_CHECK;
        end
        PH_DATA:  if (cnt_inc >= {1'b0, length_r}) phase_nxt = PH_CHECK;
        PH_CHECK: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin : datapath
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    len_hi_nxt     = len_hi_r;
    length_nxt     = length_r;
    wr_en          = 1'b0;
    drain_nxt      = drain_r;
    rd_ptr_nxt     = rd_ptr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_dv_nxt     = out_dv_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_cmd_nxt    = out_cmd_r;
    out_len_nxt    = out_len_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == hdr1_r) begin
            sum_nxt = in_rx_byte;
            cnt_nxt = '0;
          end
        end
        PH_HEAD1: begin
          if (in_rx_byte == hdr2_r) sum_nxt = sum_r + in_rx_byte;
          else cnt_nxt = '0;
        end
        PH_HEAD2: begin
          if (in_rx_byte == ver_r) sum_nxt = sum_r + in_rx_byte;
          else cnt_nxt = '0;
        end
        PH_VER: begin
          cmd_nxt = in_rx_byte;
          sum_nxt = sum_r + in_rx_byte;
        end
        PH_CMD: begin
          len_hi_nxt = in_rx_byte;
          sum_nxt    = sum_r + in_rx_byte;
        end
        PH_LENHI: begin
          sum_nxt    = sum_r + in_rx_byte;
          cnt_nxt    = '0;
          length_nxt = in_rx_byte[LEN_W-1:0];
        end
        PH_DATA: begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_inc[LEN_W-1:0];
          sum_nxt = sum_r + in_rx_byte;
        end
        PH_CHECK: begin
          cnt_nxt = '0;
          if (!sum_ok || (length_r == '0)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = !sum_ok;
            out_dv_nxt     = 1'b0;
            out_idx_nxt    = '0;
            out_last_nxt   = 1'b1;
            out_cmd_nxt    = cmd_r;
            out_len_nxt    = length_r;
          end else begin
            drain_nxt  = 1'b1;
            rd_ptr_nxt = '0;
          end
        end
      endcase
    end
    // advance the drain one entry per free output slot
    if (rd_issue) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = 1'b0;
      out_dv_nxt     = 1'b1;
      out_idx_nxt    = rd_ptr_r[IDX_W-1:0];
      out_last_nxt   = (rd_next == {1'b0, length_r});
      out_cmd_nxt    = cmd_r;
      out_len_nxt    = length_r;
      rd_ptr_nxt     = rd_next[LEN_W-1:0];
      if (rd_next == {1'b0, length_r}) drain_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r      <= HEADER_FIRST_RST;
      hdr2_r      <= HEADER_SECOND_RST;
      ver_r       <= PROTOCOL_VERSION_RST;
      limit_r     <= LENGTH_LIMIT_RST;
      phase_r     <= PH_IDLE;
      sum_r       <= '0;
      cnt_r       <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_HEADER_FIRST:     hdr1_r  <= cfg_wdata;
          REG_HEADER_SECOND:    hdr2_r  <= cfg_wdata;
          REG_PROTOCOL_VERSION: ver_r   <= cfg_wdata;
          REG_LENGTH_LIMIT:     limit_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    len_hi_r     <= len_hi_nxt;
    length_r     <= length_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    out_status_r <= out_status_nxt;
    out_dv_r     <= out_dv_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
    out_cmd_r    <= out_cmd_nxt;
    out_len_r    <= out_len_nxt;
  end

  // payload store: one write port while receiving, one read port while draining
  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[AW-1:0]] <= in_rx_byte;
    if (rd_issue) rd_data_r <= mem[rd_ptr_r[AW-1:0]];
  end

  assign out_valid          = out_valid_r;
  assign out_frame_status   = out_status_r;
  assign out_command        = out_cmd_r;
  assign out_payload_length = out_len_r;
  assign out_data_valid     = out_dv_r;
  assign out_payload_byte   = out_dv_r ? rd_data_r : '0;
  assign out_byte_index     = out_idx_r;
  assign out_last           = out_last_r;

  `SFD_ASSERT_NOW(a_drain_blocks_input, drain_r, in_stall, "input transfer during drain")
  `SFD_ASSERT_NOW(a_drain_in_idle, drain_r, phase_r == PH_IDLE, "drain while parsing")
  `SFD_ASSERT_NEXT(a_drain_holds, drain_r && out_valid_r && out_stall,
                   $stable(rd_ptr_r) && drain_r, "drain advanced into a stalled slot")
  `SFD_ASSERT_NOW(a_index_in_range, out_valid_r && out_dv_r, {1'b0, out_idx_r} < out_len_r,
                  "payload index beyond frame length")

endmodule
`default_nettype wire
